FILE: hw/rtl/mbs_pkg.sv
// mbs_pkg: shared widths, types and result codes for the sphere merge
// pipeline. No dependencies; used by mbs_sqrt, mbs_div and the top level.
`default_nettype none
package mbs_pkg;

  localparam int CW   = 32;              // center coordinate width
  localparam int RW   = 31;              // input radius width
  localparam int DW   = 33;              // center difference width
  localparam int ORW  = 33;              // merged radius width
  localparam int SQW  = 66;              // one squared difference
  localparam int L2W  = 68;              // sum of three squares
  localparam int RTW  = 35;              // square root width
  localparam int REMW = 70;              // square root remainder width
  localparam int FW   = 36;              // clamped length + radius difference
  localparam int PW   = DW + FW;         // dividend width
  localparam int DENW = RTW + 1;         // divisor 2 * length
  localparam int DRW  = DENW + 1;        // divider remainder width
  localparam int QW   = 34;              // quotient width
  localparam int TOLW = 16;              // tolerance register width

  typedef enum logic [1:0] {
    CASE_SECOND     = 2'd0,
    CASE_FIRST      = 2'd1,
    CASE_MERGED     = 2'd2,
    CASE_COINCIDENT = 2'd3
  } case_e;

  // data that rides along the square root stages
  typedef struct packed {
    logic [2:0][CW-1:0] c0;
    logic [2:0][CW-1:0] c1;
    logic [2:0][DW-1:0] d;
    logic [RW-1:0]      r0;
    logic [RW-1:0]      r1;
    logic               contain;
    logic               second;
  } sq_side_t;

  // data that rides along the divider stages
  typedef struct packed {
    logic [2:0][CW-1:0] center;
    logic [2:0]         neg;
    logic [ORW-1:0]     radius;
    case_e              mcase;
  } dv_side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mbs_sqrt.sv
// mbs_sqrt: pipelined floor square root, one result bit per stage.
// Depends on mbs_pkg for widths and the side-band type.
`default_nettype none
module mbs_sqrt (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    in_valid_i,
  input  wire logic [mbs_pkg::L2W-1:0] in_n_i,
  input  wire mbs_pkg::sq_side_t       in_side_i,
  output logic                         out_valid_o,
  output logic [mbs_pkg::RTW-1:0]      out_root_o,
  output mbs_pkg::sq_side_t            out_side_o
);

  localparam int N    = mbs_pkg::RTW;
  localparam int REMW = mbs_pkg::REMW;

  logic                valid_q [N];
  logic [REMW-1:0]     rem_q   [N];
  logic [N-1:0]        root_q  [N];
  mbs_pkg::sq_side_t   side_q  [N];

  logic                valid_in [N];
  logic [REMW-1:0]     rem_in   [N];
  logic [N-1:0]        root_in  [N];
  mbs_pkg::sq_side_t   side_in  [N];
  logic [REMW-1:0]     rem_d    [N];
  logic [N-1:0]        root_d   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [REMW-1:0] trial;

    // stage input from the port or the previous stage
    if (k == 0) begin : g_first
      assign valid_in[k] = in_valid_i;
      assign rem_in[k]   = REMW'(in_n_i);
      assign root_in[k]  = '0;
      assign side_in[k]  = in_side_i;
    end else begin : g_next
      assign valid_in[k] = valid_q[k-1];
      assign rem_in[k]   = rem_q[k-1];
      assign root_in[k]  = root_q[k-1];
      assign side_in[k]  = side_q[k-1];
    end

    // try setting result bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    always_comb begin
      trial     = (REMW'(root_in[k]) << (B + 1)) | (REMW'(1) << (2 * B));
      rem_d[k]  = rem_in[k];
      root_d[k] = root_in[k];
      if (rem_in[k] >= trial) begin
        rem_d[k]     = rem_in[k] - trial;
        root_d[k][B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid_o = valid_q[N-1];
  assign out_root_o  = root_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule
`default_nettype wire

FILE: hw/rtl/mbs_div.sv
// mbs_div: pipelined restoring divider, one quotient bit per stage, three
// dividends over one shared divisor. Depends on mbs_pkg.
`default_nettype none
module mbs_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             in_valid_i,
  input  wire logic [2:0][mbs_pkg::PW-1:0]      in_num_i,
  input  wire logic [mbs_pkg::DENW-1:0]         in_den_i,
  input  wire mbs_pkg::dv_side_t                in_side_i,
  output logic                                  out_valid_o,
  output logic [2:0][mbs_pkg::QW-1:0]           out_quot_o,
  output mbs_pkg::dv_side_t                     out_side_o
);

  localparam int N   = mbs_pkg::QW;
  localparam int PW  = mbs_pkg::PW;
  localparam int DRW = mbs_pkg::DRW;

  logic                         valid_q [N];
  logic [2:0][DRW-1:0]          rem_q   [N];
  logic [2:0][N-1:0]            quot_q  [N];
  logic [2:0][PW-1:0]           num_q   [N];
  logic [mbs_pkg::DENW-1:0]     den_q   [N];
  mbs_pkg::dv_side_t            side_q  [N];

  logic                         valid_in [N];
  logic [2:0][DRW-1:0]          rem_in   [N];
  logic [2:0][N-1:0]            quot_in  [N];
  logic [2:0][PW-1:0]           num_in   [N];
  logic [mbs_pkg::DENW-1:0]     den_in   [N];
  mbs_pkg::dv_side_t            side_in  [N];
  logic [2:0][DRW-1:0]          rem_d    [N];
  logic [2:0][N-1:0]            quot_d   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int I = N - 1 - k;
    logic [DRW-1:0] shifted [3];

    // stage input; the upper dividend bits seed the remainder
    if (k == 0) begin : g_first
      assign valid_in[k] = in_valid_i;
      for (genvar a = 0; a < 3; a++) begin : g_seed
        assign rem_in[k][a] = DRW'(in_num_i[a][PW-1:N]);
      end
      assign quot_in[k]  = '0;
      assign num_in[k]   = in_num_i;
      assign den_in[k]   = in_den_i;
      assign side_in[k]  = in_side_i;
    end else begin : g_next
      assign valid_in[k] = valid_q[k-1];
      assign rem_in[k]   = rem_q[k-1];
      assign quot_in[k]  = quot_q[k-1];
      assign num_in[k]   = num_q[k-1];
      assign den_in[k]   = den_q[k-1];
      assign side_in[k]  = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        shifted[a]   = {rem_in[k][a][DRW-2:0], num_in[k][a][I]};
        rem_d[k][a]  = shifted[a];
        quot_d[k][a] = quot_in[k][a];
        if (shifted[a] >= {1'b0, den_in[k]}) begin
          rem_d[k][a]     = shifted[a] - {1'b0, den_in[k]};
          quot_d[k][a][I] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d[k];
        quot_q[k] <= quot_d[k];
        num_q[k]  <= num_in[k];
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign out_valid_o = valid_q[N-1];
  assign out_quot_o  = quot_q[N-1];
  assign out_side_o  = side_q[N-1];

endmodule
`default_nettype wire

FILE: hw/rtl/merge_bounding_spheres.sv
// merge_bounding_spheres: smallest sphere holding two spheres, Q16.16.
// Throughput is one item per cycle while the output is not stalled, through
// the 35-stage square root and the 34-stage divider pipelines.
// A stalled output freezes every stage; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits and the tolerance.
// Depends on mbs_pkg, mbs_sqrt and mbs_div.
`default_nettype none
module merge_bounding_spheres (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbs_pkg::TOLW-1:0]      cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [mbs_pkg::CW-1:0] first_center_x_i,
  input  wire logic signed [mbs_pkg::CW-1:0] first_center_y_i,
  input  wire logic signed [mbs_pkg::CW-1:0] first_center_z_i,
  input  wire logic [mbs_pkg::RW-1:0]        first_radius_i,
  input  wire logic signed [mbs_pkg::CW-1:0] second_center_x_i,
  input  wire logic signed [mbs_pkg::CW-1:0] second_center_y_i,
  input  wire logic signed [mbs_pkg::CW-1:0] second_center_z_i,
  input  wire logic [mbs_pkg::RW-1:0]        second_radius_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [mbs_pkg::CW-1:0]      merged_center_x_o,
  output logic signed [mbs_pkg::CW-1:0]      merged_center_y_o,
  output logic signed [mbs_pkg::CW-1:0]      merged_center_z_o,
  output logic [mbs_pkg::ORW-1:0]            merged_radius_o,
  output logic [1:0]                         merge_case_o
);

  localparam int CW  = mbs_pkg::CW;
  localparam int DW  = mbs_pkg::DW;
  localparam int RW  = mbs_pkg::RW;
  localparam int RTW = mbs_pkg::RTW;
  localparam int FW  = mbs_pkg::FW;

  logic en;
  logic [mbs_pkg::TOLW-1:0] tol_q;

  // whole pipeline advances unless the output holds an untaken result
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // stage 1: differences
  logic                   s1_valid_q;
  logic [2:0][CW-1:0]     s1_c0_q, s1_c1_q;
  logic [2:0][DW-1:0]     s1_d_q;
  logic [RW-1:0]          s1_r0_q, s1_r1_q;
  logic [CW-1:0]          s1_rd_q;
  logic [2:0][CW-1:0]     c0_w, c1_w;
  logic [2:0][DW-1:0]     d_w;

  assign c0_w = {first_center_z_i, first_center_y_i, first_center_x_i};
  assign c1_w = {second_center_z_i, second_center_y_i, second_center_x_i};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_w[a] = {c1_w[a][CW-1], c1_w[a]} - {c0_w[a][CW-1], c0_w[a]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_c0_q <= c0_w;
      s1_c1_q <= c1_w;
      s1_d_q  <= d_w;
      s1_r0_q <= first_radius_i;
      s1_r1_q <= second_radius_i;
      s1_rd_q <= {1'b0, second_radius_i} - {1'b0, first_radius_i};
    end
  end

  // stage 2: squares
  logic                       s2_valid_q;
  logic [2:0][mbs_pkg::SQW-1:0] s2_sq_q;
  logic [2*RW-1:0]            s2_rd2_q;
  logic [2:0][CW-1:0]         s2_c0_q, s2_c1_q;
  logic [2:0][DW-1:0]         s2_d_q;
  logic [RW-1:0]              s2_r0_q, s2_r1_q;
  logic                       s2_rdneg_q;
  logic [2:0][DW-1:0]         s1_mag;
  logic [RW-1:0]              rd_mag;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s1_mag[a] = s1_d_q[a][DW-1] ? (~s1_d_q[a] + DW'(1)) : s1_d_q[a];
    end
    rd_mag = s1_rd_q[CW-1] ? RW'(~s1_rd_q + CW'(1)) : RW'(s1_rd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s2_sq_q[a] <= mbs_pkg::SQW'(s1_mag[a]) * mbs_pkg::SQW'(s1_mag[a]);
      end
      s2_rd2_q   <= (2*RW)'(rd_mag) * (2*RW)'(rd_mag);
      s2_c0_q    <= s1_c0_q;
      s2_c1_q    <= s1_c1_q;
      s2_d_q     <= s1_d_q;
      s2_r0_q    <= s1_r0_q;
      s2_r1_q    <= s1_r1_q;
      s2_rdneg_q <= s1_rd_q[CW-1];
    end
  end

  // stage 3: squared distance and containment test
  logic                        s3_valid_q;
  logic [mbs_pkg::L2W-1:0]     s3_l2_q;
  mbs_pkg::sq_side_t           s3_side_q;
  logic [mbs_pkg::L2W-1:0]     l2_w;

  assign l2_w = mbs_pkg::L2W'(s2_sq_q[0]) + mbs_pkg::L2W'(s2_sq_q[1])
              + mbs_pkg::L2W'(s2_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_l2_q           <= l2_w;
      s3_side_q.c0      <= s2_c0_q;
      s3_side_q.c1      <= s2_c1_q;
      s3_side_q.d       <= s2_d_q;
      s3_side_q.r0      <= s2_r0_q;
      s3_side_q.r1      <= s2_r1_q;
      s3_side_q.contain <= l2_w <= mbs_pkg::L2W'(s2_rd2_q);
      s3_side_q.second  <= !s2_rdneg_q;
    end
  end

  // square root pipeline
  logic                 sq_valid;
  logic [RTW-1:0]       sq_len;
  mbs_pkg::sq_side_t    sq_side;

  mbs_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s3_valid_q),
    .in_n_i      (s3_l2_q),
    .in_side_i   (s3_side_q),
    .out_valid_o (sq_valid),
    .out_root_o  (sq_len),
    .out_side_o  (sq_side)
  );

  // stage 4: scale factor, radius and result case
  logic                   s4_valid_q;
  logic [2:0][DW-1:0]     s4_mag_q;
  logic [FW-1:0]          s4_fu_q;
  logic [mbs_pkg::DENW-1:0] s4_den_q;
  mbs_pkg::dv_side_t      s4_side_q;
  logic signed [FW:0]     f_w;
  logic [RTW:0]           rsum_w;
  logic [CW:0]            rd_w;
  mbs_pkg::dv_side_t      side4_w;

  always_comb begin
    rd_w   = {2'b00, sq_side.r1} - {2'b00, sq_side.r0};
    f_w    = $signed({2'b00, sq_len}) + $signed({{(FW-CW){rd_w[CW]}}, rd_w});
    rsum_w = {1'b0, sq_len} + (RTW+1)'(sq_side.r0) + (RTW+1)'(sq_side.r1);
    for (int a = 0; a < 3; a++) begin
      side4_w.neg[a] = sq_side.d[a][DW-1];
    end
    side4_w.center = sq_side.c0;
    side4_w.radius = rsum_w[mbs_pkg::ORW:1];
    if (sq_side.contain) begin
      side4_w.center = sq_side.second ? sq_side.c1 : sq_side.c0;
      side4_w.radius = sq_side.second ? mbs_pkg::ORW'(sq_side.r1)
                                      : mbs_pkg::ORW'(sq_side.r0);
      side4_w.mcase  = sq_side.second ? mbs_pkg::CASE_SECOND : mbs_pkg::CASE_FIRST;
    end else if (sq_len <= RTW'(tol_q) || sq_len == '0) begin
      side4_w.mcase  = mbs_pkg::CASE_COINCIDENT;
    end else begin
      side4_w.mcase  = mbs_pkg::CASE_MERGED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s4_mag_q[a] <= sq_side.d[a][DW-1] ? (~sq_side.d[a] + DW'(1)) : sq_side.d[a];
      end
      s4_fu_q   <= f_w[FW] ? '0 : f_w[FW-1:0];
      s4_den_q  <= {sq_len, 1'b0};
      s4_side_q <= side4_w;
    end
  end

  // stage 5: dividends
  logic                      s5_valid_q;
  logic [2:0][mbs_pkg::PW-1:0] s5_num_q;
  logic [mbs_pkg::DENW-1:0]  s5_den_q;
  mbs_pkg::dv_side_t         s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s5_num_q[a] <= mbs_pkg::PW'(s4_mag_q[a]) * mbs_pkg::PW'(s4_fu_q);
      end
      s5_den_q  <= s4_den_q;
      s5_side_q <= s4_side_q;
    end
  end

  // divider pipeline
  logic                        dv_valid;
  logic [2:0][mbs_pkg::QW-1:0] dv_quot;
  mbs_pkg::dv_side_t           dv_side;

  mbs_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s5_valid_q),
    .in_num_i    (s5_num_q),
    .in_den_i    (s5_den_q),
    .in_side_i   (s5_side_q),
    .out_valid_o (dv_valid),
    .out_quot_o  (dv_quot),
    .out_side_o  (dv_side)
  );

  // output register: apply signed offset for merged spheres
  logic [2:0][CW-1:0] center_w;
  logic [2:0][CW-1:0] out_center_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      center_w[a] = dv_side.center[a];
      if (dv_side.mcase == mbs_pkg::CASE_MERGED) begin
        center_w[a] = dv_side.neg[a] ? dv_side.center[a] - CW'(dv_quot[a])
                                     : dv_side.center[a] + CW'(dv_quot[a]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_center_q    <= center_w;
      merged_radius_o <= dv_side.radius;
      merge_case_o    <= dv_side.mcase;
    end
  end

  assign merged_center_x_o = out_center_q[0];
  assign merged_center_y_o = out_center_q[1];
  assign merged_center_z_o = out_center_q[2];

  // a contained sphere keeps its 31-bit radius
  a_contain_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (merge_case_o == mbs_pkg::CASE_SECOND ||
                    merge_case_o == mbs_pkg::CASE_FIRST)
    |-> merged_radius_o[mbs_pkg::ORW-1:RW] == '0)
    else $error("contained result with oversized radius");

  // input is held off only while a result waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // a pending result is not replaced while stalled
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(merged_radius_o)
                                    && $stable(merge_case_o))
    else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: dv/merge_bounding_spheres_checker.sv
// sphere merge checker: watches the input and result channels, predicts
// each merged sphere and compares it field by field. Depends on mbs_pkg.
module merge_bounding_spheres_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbs_pkg::TOLW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [31:0]            first_center_x_i,
  input  logic signed [31:0]            first_center_y_i,
  input  logic signed [31:0]            first_center_z_i,
  input  logic [30:0]                   first_radius_i,
  input  logic signed [31:0]            second_center_x_i,
  input  logic signed [31:0]            second_center_y_i,
  input  logic signed [31:0]            second_center_z_i,
  input  logic [30:0]                   second_radius_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [31:0]            merged_center_x_i,
  input  logic signed [31:0]            merged_center_y_i,
  input  logic signed [31:0]            merged_center_z_i,
  input  logic [32:0]                   merged_radius_i,
  input  logic [1:0]                    merge_case_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] cx, cy, cz;
    logic [32:0]        radius;
    mbs_pkg::case_e     mcase;
  } sphere_t;

  sphere_t expected_spheres[$];
  logic [15:0] tolerance;
  int mismatches;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_spheres.size();

  // floor square root of a 68-bit value
  function automatic logic [34:0] isqrt(input logic [67:0] n);
    logic [34:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      if ({33'd0, c} * {33'd0, c} <= {2'd0, n}) r = c;
    end
    return r;
  endfunction

  function automatic sphere_t merge_spheres(
    input logic signed [31:0] a[3], input logic [30:0] ra,
    input logic signed [31:0] b[3], input logic [30:0] rb,
    input logic [15:0] tol);
    sphere_t s;
    logic signed [32:0] d[3];
    logic [32:0] dm;
    logic [67:0] l2;
    logic signed [32:0] rdiff;
    logic [67:0] rd2;
    logic [34:0] len;
    logic signed [36:0] f;
    logic [35:0] fu;
    logic [71:0] q;
    logic signed [31:0] res[3];
    l2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 33'(b[i]) - 33'(a[i]);
      dm = d[i][32] ? -d[i] : d[i];
      l2 += {35'd0, dm} * {35'd0, dm};
    end
    rdiff = $signed({2'b0, rb}) - $signed({2'b0, ra});
    dm = rdiff[32] ? -rdiff : rdiff;
    rd2 = {35'd0, dm} * {35'd0, dm};
    if (l2 <= rd2) begin
      if (!rdiff[32]) begin
        s.cx = b[0]; s.cy = b[1]; s.cz = b[2];
        s.radius = {2'b0, rb}; s.mcase = mbs_pkg::CASE_SECOND;
      end else begin
        s.cx = a[0]; s.cy = a[1]; s.cz = a[2];
        s.radius = {2'b0, ra}; s.mcase = mbs_pkg::CASE_FIRST;
      end
      return s;
    end
    len = isqrt(l2);
    if (len > {19'd0, tol} && len != 0) begin
      f  = $signed({2'b0, len}) + 37'(rdiff);
      fu = f[36] ? '0 : f[35:0];
      for (int i = 0; i < 3; i++) begin
        dm = d[i][32] ? -d[i] : d[i];
        q = ({39'd0, dm} * {36'd0, fu}) / {36'd0, len, 1'b0};
        res[i] = d[i][32] ? a[i] - q[31:0] : a[i] + q[31:0];
      end
      s.cx = res[0]; s.cy = res[1]; s.cz = res[2];
      s.mcase = mbs_pkg::CASE_MERGED;
    end else begin
      s.cx = a[0]; s.cy = a[1]; s.cz = a[2];
      s.mcase = mbs_pkg::CASE_COINCIDENT;
    end
    s.radius = 33'(({1'b0, len} + 36'(ra) + 36'(rb)) >> 1);
    return s;
  endfunction

  // predict on input transfer, compare on result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    sphere_t e;
    logic signed [31:0] a[3];
    logic signed [31:0] b[3];
    if (!rst_ni) begin
      tolerance  <= '0;
      mismatches <= 0;
      expected_spheres.delete();
    end else begin
      if (cfg_we_i) tolerance <= cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        a = '{first_center_x_i, first_center_y_i, first_center_z_i};
        b = '{second_center_x_i, second_center_y_i, second_center_z_i};
        expected_spheres.push_back(
          merge_spheres(a, first_radius_i, b, second_radius_i, tolerance));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_spheres.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer");
          mismatches <= mismatches + 1;
        end else begin
          e = expected_spheres.pop_front();
          if (e.cx !== merged_center_x_i || e.cy !== merged_center_y_i ||
              e.cz !== merged_center_z_i || e.radius !== merged_radius_i ||
              e.mcase !== merge_case_i) begin
            if (mismatches < 10)
              $display("bad result: exp %h %h %h r=%h c=%0d got %h %h %h r=%h c=%0d",
                       e.cx, e.cy, e.cz, e.radius, e.mcase, merged_center_x_i,
                       merged_center_y_i, merged_center_z_i, merged_radius_i,
                       merge_case_i);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

FILE: dv/merge_bounding_spheres_test.sv
// sphere merge testbench top: drives directed and random sphere pairs and
// tolerance settings, with bursty input and stalling output.
// Depends on mbs_pkg, merge_bounding_spheres and its checker.
module merge_bounding_spheres_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 75;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [mbs_pkg::TOLW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] c0x = 0, c0y = 0, c0z = 0, c1x = 0, c1y = 0, c1z = 0;
  logic [30:0] r0 = 0, r1 = 0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] mx, my, mz;
  logic [32:0] mr;
  logic [1:0] mc;
  int fails, pending;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stall_on = 1'b1;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  merge_bounding_spheres u_top (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .first_center_x_i(c0x), .first_center_y_i(c0y), .first_center_z_i(c0z),
    .first_radius_i(r0),
    .second_center_x_i(c1x), .second_center_y_i(c1y), .second_center_z_i(c1z),
    .second_radius_i(r1),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .merged_center_x_o(mx), .merged_center_y_o(my), .merged_center_z_o(mz),
    .merged_radius_o(mr), .merge_case_o(mc)
  );

  merge_bounding_spheres_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .first_center_x_i(c0x), .first_center_y_i(c0y), .first_center_z_i(c0z),
    .first_radius_i(r0),
    .second_center_x_i(c1x), .second_center_y_i(c1y), .second_center_z_i(c1z),
    .second_radius_i(r1),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .merged_center_x_i(mx), .merged_center_y_i(my), .merged_center_z_i(mz),
    .merged_radius_i(mr), .merge_case_i(mc),
    .fail_count_o(fails), .pending_o(pending)
  );

  // timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off) out_ready <= 1'b0;
    else if (!stall_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // present one pair and wait for its transfer; valid stays high for a
  // following pair in the same burst
  task automatic send_pair(input logic signed [31:0] ax, ay, az, input logic [30:0] ar,
                           input logic signed [31:0] bx, by, bz, input logic [30:0] br);
    c0x <= ax; c0y <= ay; c0z <= az; r0 <= ar;
    c1x <= bx; c1y <= by; c1z <= bz; r1 <= br;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // drop valid at the end of a burst
  task automatic end_burst();
    in_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_tolerance(input logic [15:0] value);
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(0, 200));
    endcase
  endfunction

  function automatic logic [30:0] rand_radius(input int mode);
    case (mode)
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 32'h0004_0000));
      default: return 31'($urandom_range(0, 300));
    endcase
  endfunction

  task automatic random_phase(input int count);
    int sent;
    int burst;
    int m;
    logic signed [31:0] ax, ay, az;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < count; k++) begin
        m = $urandom_range(0, 2);
        ax = rand_coord(m); ay = rand_coord(m); az = rand_coord(m);
        if ($urandom_range(0, 9) == 0)
          // near-coincident or containment pair
          send_pair(ax, ay, az, rand_radius(m), ax + $urandom_range(0, 3), ay, az,
                    rand_radius(m));
        else
          send_pair(ax, ay, az, rand_radius(m),
                    m == 0 ? rand_coord(0) : ax + rand_coord(m),
                    m == 0 ? rand_coord(0) : ay + rand_coord(m),
                    m == 0 ? rand_coord(0) : az + rand_coord(m), rand_radius(m));
        sent++;
      end
      end_burst();
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  localparam logic signed [31:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;
  localparam logic [30:0] RMAX = 31'h7fff_ffff;

  initial begin
    int wait_cycles;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extremes, containment both ways, ties, coincident centers
    stall_on = 1'b0;
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(5, 6, 7, 100, 5, 6, 7, 100);
    send_pair(0, 0, 0, 1000, 10, 0, 0, 5);
    send_pair(0, 0, 0, 5, 10, 0, 0, 1000);
    send_pair(CMIN, CMIN, CMIN, 0, CMAX, CMAX, CMAX, 0);
    send_pair(CMAX, CMIN, CMAX, RMAX, CMIN, CMAX, CMIN, RMAX);
    send_pair(CMIN, CMAX, 0, RMAX, CMAX, CMIN, 0, 0);
    send_pair(0, 0, 0, RMAX, 1, 0, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0, 0, RMAX);
    send_pair(0, 0, 0, 0, 32'sh0001_0000, 0, 0, 0);
    send_pair(-3, 4, 0, 0, 3, -4, 0, 1);
    send_pair(0, 0, 0, 0, 1, 1, 1, 0);
    send_pair(-32'sh10000, 0, 0, 31'h8000, 32'sh10000, 0, 0, 31'h18000);
    send_pair(100, -200, 300, 7, -100, 200, -300, 0);
    end_burst();
    stall_on = 1'b1;
    random_phase(150);

    write_tolerance(16'hffff);
    send_pair(0, 0, 0, 0, 32'h0000_ffff, 0, 0, 0);
    send_pair(0, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
    end_burst();
    random_phase(350);

    // long receiver hold-off while the sender keeps going
    write_tolerance(16'd200);
    fork
      begin
        hold_off = 1'b1;
        wait_cycles = 300;
        repeat (wait_cycles) @(negedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(350);
    join

    write_tolerance(16'd0);
    stall_on = 1'b0;
    random_phase(80);
    stall_on = 1'b1;
    random_phase(300);

    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
